[rtl/sfuce_pkg.sv]
// Shared types and constants for the SPI flash update command engine.
// No dependencies.
package sfuce_pkg;

    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned ERASE_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WORDS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORDS    = 2'd3;

    localparam logic [31:0] RST_BASE_ADDRESS = 32'h0800_0000;
    localparam logic [7:0]  RST_MAX_ERASE    = 8'd30;
    localparam logic [15:0] RST_MIN_WORDS    = 16'd50;
    localparam logic [15:0] RST_MAX_WORDS    = 16'd30720;

    localparam logic [7:0] ERASE_CAP = 8'd30;

    localparam logic [7:0] CMD_ERASE    = 8'd100;
    localparam logic [7:0] CMD_PROGRAM  = 8'd101;
    localparam logic [7:0] CMD_READ     = 8'd102;
    localparam logic [7:0] CMD_RESET_A  = 8'd150;
    localparam logic [7:0] CMD_RESET_B  = 8'd151;

    localparam logic [15:0] WORD_ERASE_DONE = 16'hAAAA;
    localparam logic [15:0] WORD_CMD_ACK    = 16'hCCCC;
    localparam logic [15:0] WORD_PROG_ACK   = 16'h1111;

    typedef enum logic [2:0] {
        ACT_SEND    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_PROGRAM = 3'd2,
        ACT_READ    = 3'd3,
        ACT_RESET   = 3'd4,
        ACT_HALT    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        JOB_SEND    = 3'd0,
        JOB_ERASE   = 3'd1,
        JOB_PROGRAM = 3'd2,
        JOB_READ    = 3'd3,
        JOB_RESET   = 3'd4,
        JOB_HALT    = 3'd5
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic [31:0]            address;
        logic [15:0]            data;
        logic [ERASE_CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic [31:0] base_address;
        logic [7:0]  max_erase_pages;
        logic [15:0] min_transfer_words;
        logic [15:0] max_transfer_words;
    } t_cfg;

endpackage

[rtl/sfuce_in_if.sv]
// Input channel: one SPI word per item.
// No dependencies.
interface sfuce_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] rx_word;

    modport source (output valid, output rx_word, input ready);
    modport sink   (input valid, input rx_word, output ready);
endinterface

[rtl/sfuce_out_if.sv]
// Output channel: one flash/SPI action per item.
// No dependencies.
interface sfuce_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] address;
    logic [15:0] data;
    logic        last;

    modport source (output valid, output action, output address, output data, output last,
                    input ready);
    modport sink   (input valid, input action, input address, input data, input last,
                    output ready);
endinterface

[rtl/sfuce_front.sv]
// Front end: decodes each received word against the current mode and queues a job where the word calls for one.
// Depends on sfuce_pkg.
module sfuce_front
    import sfuce_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    input  logic [15:0] i_rx_word,
    output logic   o_ready,
    output logic   o_push,
    output t_job   o_job,
    input  logic   i_full
);

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COUNT   = 5'b00010,
        MODE_PROGRAM = 5'b00100,
        MODE_READ    = 5'b01000,
        MODE_HALT    = 5'b10000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_words_left, n_words_left;
    logic [31:0] r_next_addr, n_next_addr;
    logic        r_is_write, n_is_write;

    logic        accept;
    logic        has_job;
    logic [7:0]  cmd;
    logic [7:0]  arg;
    logic [7:0]  limit;
    logic [15:0] words_dec;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept && has_job;
    assign cmd       = i_rx_word[15:8];
    assign arg       = i_rx_word[7:0];
    assign limit     = (i_cfg.max_erase_pages < ERASE_CAP) ? i_cfg.max_erase_pages : ERASE_CAP;
    assign words_dec = r_words_left - 16'd1;

    always_comb begin
        n_mode       = r_mode;
        n_words_left = r_words_left;
        n_next_addr  = r_next_addr;
        n_is_write   = r_is_write;
        has_job      = 1'b0;
        o_job.kind    = JOB_SEND;
        o_job.address = '0;
        o_job.data    = '0;
        o_job.count   = '0;
        unique case (r_mode)
            MODE_HALT: begin
            end
            MODE_COUNT: begin
                if (i_rx_word < i_cfg.min_transfer_words ||
                    i_rx_word > i_cfg.max_transfer_words) begin
                    has_job      = 1'b1;
                    o_job.kind   = JOB_HALT;
                    n_mode       = MODE_HALT;
                    n_words_left = '0;
                    n_next_addr  = '0;
                    n_is_write   = 1'b0;
                end else begin
                    n_words_left = i_rx_word;
                    n_next_addr  = i_cfg.base_address;
                    if (i_rx_word == 16'd0) begin
                        n_mode = MODE_IDLE;
                    end else if (r_is_write) begin
                        n_mode = MODE_PROGRAM;
                    end else begin
                        n_mode = MODE_READ;
                    end
                end
            end
            MODE_PROGRAM, MODE_READ: begin
                has_job       = 1'b1;
                o_job.kind    = (r_mode == MODE_PROGRAM) ? JOB_PROGRAM : JOB_READ;
                o_job.address = r_next_addr;
                o_job.data    = (r_mode == MODE_PROGRAM) ? i_rx_word : 16'd0;
                o_job.count   = (r_mode == MODE_PROGRAM) ? ERASE_CNT_W'(1) : '0;
                n_next_addr   = r_next_addr + 32'd2;
                n_words_left  = words_dec;
                if (words_dec == 16'd0) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                unique case (cmd) inside
                    CMD_ERASE: begin
                        has_job = 1'b1;
                        if (arg == 8'd0 || arg > limit) begin
                            o_job.kind   = JOB_HALT;
                            n_mode       = MODE_HALT;
                            n_words_left = '0;
                            n_next_addr  = '0;
                            n_is_write   = 1'b0;
                        end else begin
                            o_job.kind    = JOB_ERASE;
                            o_job.address = i_cfg.base_address;
                            o_job.count   = arg[ERASE_CNT_W-1:0];
                        end
                    end
                    CMD_PROGRAM, CMD_READ: begin
                        has_job    = 1'b1;
                        o_job.kind = JOB_SEND;
                        o_job.data = WORD_CMD_ACK;
                        n_is_write = (cmd == CMD_PROGRAM);
                        n_mode     = MODE_COUNT;
                    end
                    CMD_RESET_A, CMD_RESET_B: begin
                        has_job      = 1'b1;
                        o_job.kind   = JOB_RESET;
                        n_words_left = '0;
                        n_next_addr  = '0;
                        n_is_write   = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_words_left <= '0;
            r_next_addr  <= '0;
            r_is_write   <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_words_left <= n_words_left;
            r_next_addr  <= n_next_addr;
            r_is_write   <= n_is_write;
        end
    end

endmodule

[rtl/sfuce_queue.sv]
// Two-entry job queue between the decoder and the result sequencer.
// Depends on sfuce_pkg.
module sfuce_queue
    import sfuce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/sfuce_back.sv]
// Back end: expands one queued job into its result items through an output register.
// Depends on sfuce_pkg.
module sfuce_back
    import sfuce_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic [2:0]  o_action,
    output logic [31:0] o_address,
    output logic [15:0] o_data,
    output logic        o_last
);

    logic                   r_busy;
    t_job                   r_job;
    logic [ERASE_CNT_W-1:0] r_left;
    logic [31:0]            r_addr;
    logic                   r_out_valid;
    t_action                r_action;
    logic [31:0]            r_address;
    logic [15:0]            r_data;
    logic                   r_last;

    logic    advance;
    t_action n_action;
    logic [31:0] n_address;
    logic [15:0] n_data;
    logic        n_last;

    assign advance = !r_out_valid || i_ready;
    assign o_pop   = !r_busy && i_valid;

    always_comb begin
        n_action  = ACT_SEND;
        n_address = '0;
        n_data    = '0;
        n_last    = 1'b1;
        if (r_left != '0) begin
            n_last    = 1'b0;
            n_address = r_addr;
            if (r_job.kind == JOB_PROGRAM) begin
                n_action = ACT_PROGRAM;
                n_data   = r_job.data;
            end else begin
                n_action = ACT_ERASE;
            end
        end else begin
            unique case (r_job.kind)
                JOB_ERASE:   n_data = WORD_ERASE_DONE;
                JOB_PROGRAM: n_data = WORD_PROG_ACK;
                JOB_READ: begin
                    n_action  = ACT_READ;
                    n_address = r_addr;
                end
                JOB_RESET:   n_action = ACT_RESET;
                JOB_HALT:    n_action = ACT_HALT;
                default:     n_data = r_job.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_left <= i_job.count;
            r_addr <= i_job.address;
        end else if (r_busy && advance && r_left != '0) begin
            r_left <= r_left - ERASE_CNT_W'(1);
            r_addr <= r_addr + 32'(PAGE_BYTES);
        end
        if (r_busy && advance) begin
            r_action  <= n_action;
            r_address <= n_address;
            r_data    <= n_data;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (r_busy && advance && r_left == '0) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_busy;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_action  = r_action;
    assign o_address = r_address;
    assign o_data    = r_data;
    assign o_last    = r_last;

endmodule

[rtl/spi_flash_update_command_engine_core.sv]
// Top level of the SPI flash update command engine: config registers, decoder,
// job queue and result sequencer. Depends on sfuce_pkg, sfuce_in_if, sfuce_out_if.
//
//  channel | dir | payload                         | handshake
//  i_rx    | in  | rx_word[15:0]                   | valid/ready
//  o_tx    | out | action[2:0] address data last   | valid/ready
//  i_cfg_* | in  | index[1:0] wdata[31:0]          | write enable only
//
// Decode is combinational; a two-entry job queue decouples it from the sequencer,
// which emits a job's results one per cycle while o_tx is ready and takes a new
// job from the queue only once it is done with the last. i_rx stalls only when
// the queue is full. Synchronous active-low reset returns to idle mode and
// restores the register defaults.
module spi_flash_update_command_engine_core
    import sfuce_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    sfuce_in_if.sink              i_rx,
    sfuce_out_if.source           o_tx
);

    t_cfg r_cfg;
    logic q_push;
    t_job q_in_job;
    logic q_full;
    logic q_valid;
    t_job q_out_job;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address       <= RST_BASE_ADDRESS;
            r_cfg.max_erase_pages    <= RST_MAX_ERASE;
            r_cfg.min_transfer_words <= RST_MIN_WORDS;
            r_cfg.max_transfer_words <= RST_MAX_WORDS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_ADDRESS: r_cfg.base_address       <= i_cfg_wdata;
                CFG_MAX_ERASE:    r_cfg.max_erase_pages    <= i_cfg_wdata[7:0];
                CFG_MIN_WORDS:    r_cfg.min_transfer_words <= i_cfg_wdata[15:0];
                CFG_MAX_WORDS:    r_cfg.max_transfer_words <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    sfuce_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_rx.valid),
        .i_rx_word (i_rx.rx_word),
        .o_ready   (i_rx.ready),
        .o_push    (q_push),
        .o_job     (q_in_job),
        .i_full    (q_full)
    );

    sfuce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job),
        .i_pop   (q_pop)
    );

    sfuce_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_job     (q_out_job),
        .o_pop     (q_pop),
        .o_valid   (o_tx.valid),
        .i_ready   (o_tx.ready),
        .o_action  (o_tx.action),
        .o_address (o_tx.address),
        .o_data    (o_tx.data),
        .o_last    (o_tx.last)
    );

endmodule

[verif/tb_spi_flash_update_command_engine_core.sv]
// Self-checking testbench for spi_flash_update_command_engine_core: random and directed SPI words,
// bursty sender, stalling receiver, in-bench predictor with an ordered store of expected actions.
// Depends on sfuce_pkg, sfuce_in_if, sfuce_out_if and the core RTL.
module tb_spi_flash_update_command_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sfuce_pkg::*;

    localparam int unsigned PAGE_BYTES   = 1024;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 1_000_000;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COUNT,
        MODE_PROGRAM,
        MODE_READ,
        MODE_HALT
    } t_engine_mode;

    typedef struct packed {
        t_action     action;
        logic [31:0] address;
        logic [15:0] data;
        logic        last;
    } t_flash_action;

    class flash_cmd_scoreboard;
        logic [31:0]   base_address;
        logic [7:0]    max_erase;
        logic [15:0]   min_words;
        logic [15:0]   max_words;
        t_engine_mode  mode;
        logic [15:0]   words_left;
        logic [31:0]   next_address;
        logic          is_write;
        t_flash_action pending[$];
        int            errors;
        int            checked;
        int            words_noted;

        function new();
            base_address = RST_BASE_ADDRESS;
            max_erase    = RST_MAX_ERASE;
            min_words    = RST_MIN_WORDS;
            max_words    = RST_MAX_WORDS;
            errors       = 0;
            checked      = 0;
            words_noted  = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode         = MODE_IDLE;
            words_left   = 16'd0;
            next_address = 32'd0;
            is_write     = 1'b0;
        endfunction

        function void push(t_action act, logic [31:0] addr, logic [15:0] data);
            t_flash_action r;
            r.action  = act;
            r.address = addr;
            r.data    = data;
            r.last    = 1'b0;
            pending.push_back(r);
        endfunction

        function void enter_halt();
            clear_state();
            mode = MODE_HALT;
            push(ACT_HALT, 32'd0, 16'd0);
        endfunction

        function void step_address();
            next_address = next_address + 32'd2;
            words_left   = words_left - 16'd1;
            if (words_left == 16'd0) mode = MODE_IDLE;
        endfunction

        function void note_word(logic [15:0] w);
            int         n0;
            logic [7:0] cmd;
            logic [7:0] arg;
            logic [7:0] limit;
            n0 = pending.size();
            words_noted++;
            case (mode)
                MODE_HALT: ;
                MODE_COUNT: begin
                    if (w < min_words || w > max_words) begin
                        enter_halt();
                    end else begin
                        words_left   = w;
                        next_address = base_address;
                        if (w == 16'd0) mode = MODE_IDLE;
                        else mode = is_write ? MODE_PROGRAM : MODE_READ;
                    end
                end
                MODE_PROGRAM: begin
                    push(ACT_PROGRAM, next_address, w);
                    push(ACT_SEND, 32'd0, WORD_PROG_ACK);
                    step_address();
                end
                MODE_READ: begin
                    push(ACT_READ, next_address, 16'd0);
                    step_address();
                end
                default: begin
                    cmd   = w[15:8];
                    arg   = w[7:0];
                    limit = (max_erase < ERASE_CAP) ? max_erase : ERASE_CAP;
                    mode  = MODE_IDLE;
                    case (cmd)
                        CMD_ERASE: begin
                            if (arg == 8'd0 || arg > limit) begin
                                enter_halt();
                            end else begin
                                for (int i = 0; i < int'(arg); i++)
                                    push(ACT_ERASE, base_address + 32'(i * PAGE_BYTES), 16'd0);
                                push(ACT_SEND, 32'd0, WORD_ERASE_DONE);
                            end
                        end
                        CMD_PROGRAM, CMD_READ: begin
                            is_write = (cmd == CMD_PROGRAM);
                            mode     = MODE_COUNT;
                            push(ACT_SEND, 32'd0, WORD_CMD_ACK);
                        end
                        CMD_RESET_A, CMD_RESET_B: begin
                            clear_state();
                            push(ACT_RESET, 32'd0, 16'd0);
                        end
                        default: ;
                    endcase
                end
            endcase
            if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [2:0] act, logic [31:0] addr, logic [15:0] data,
                                   logic last);
            t_flash_action exp;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $error("unexpected item: action %0d address %h data %h last %0b",
                       act, addr, data, last);
                return;
            end
            exp = pending.pop_front();
            if (act !== exp.action) begin
                errors++;
                $error("action: expected %0d, got %0d", exp.action, act);
            end
            if (addr !== exp.address) begin
                errors++;
                $error("address: expected %h, got %h", exp.address, addr);
            end
            if (data !== exp.data) begin
                errors++;
                $error("data: expected %h, got %h", exp.data, data);
            end
            if (last !== exp.last) begin
                errors++;
                $error("last: expected %0b, got %0b", exp.last, last);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    sfuce_in_if  rx_if();
    sfuce_out_if tx_if();

    flash_cmd_scoreboard sb = new();
    int                  burst_left = 0;
    int                  settings = 0;

    spi_flash_update_command_engine_core #(.PAGE_BYTES(PAGE_BYTES)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_if),
        .o_tx        (tx_if)
    );

    always #4 i_clk = ~i_clk;

    task automatic send_word(input logic [15:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                rx_if.valid   <= 1'b0;
                rx_if.rx_word <= 16'($urandom_range(0, 65535));
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_word <= w;
        do @(posedge i_clk); while (!rx_if.ready);
        sb.note_word(w);
    endtask

    task automatic settle();
        rx_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] base, input logic [7:0] max_erase,
                               input logic [15:0] min_w, input logic [15:0] max_w);
        put_reg(CFG_BASE_ADDRESS, base);
        put_reg(CFG_MAX_ERASE, 32'(max_erase));
        put_reg(CFG_MIN_WORDS, 32'(min_w));
        put_reg(CFG_MAX_WORDS, 32'(max_w));
        i_cfg_we        <= 1'b0;
        sb.base_address = base;
        sb.max_erase    = max_erase;
        sb.min_words    = min_w;
        sb.max_words    = max_w;
        settings++;
    endtask

    // well-formed command sequences with random content, plus ignored commands
    task automatic run_traffic(input int target);
        int          sent;
        int          pick;
        int          span;
        int          cnt;
        logic [7:0]  lim;
        logic [7:0]  cmd;
        logic [15:0] data;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            lim  = (sb.max_erase < ERASE_CAP) ? sb.max_erase : ERASE_CAP;
            if (pick < 30) begin
                send_word({CMD_ERASE, 8'($urandom_range(1, lim))});
                sent++;
            end else if (pick < 72) begin
                send_word({(($urandom_range(0, 1) != 0) ? CMD_PROGRAM : CMD_READ),
                           8'($urandom_range(0, 255))});
                span = int'(sb.max_words) - int'(sb.min_words);
                if (span > 12) span = 12;
                cnt = int'(sb.min_words) + $urandom_range(0, span);
                if (int'(sb.max_words) - int'(sb.min_words) <= 64 && $urandom_range(0, 3) == 0)
                    cnt = int'(sb.max_words);
                send_word(16'(cnt));
                repeat (cnt) begin
                    data = 16'($urandom_range(0, 65535));
                    // command-like words inside a transfer must be taken as data
                    if ($urandom_range(0, 3) == 0)
                        data[15:8] = ($urandom_range(0, 1) != 0) ? CMD_RESET_A : CMD_ERASE;
                    send_word(data);
                end
                sent += cnt + 2;
            end else if (pick < 82) begin
                send_word({(($urandom_range(0, 1) != 0) ? CMD_RESET_A : CMD_RESET_B),
                           8'($urandom_range(0, 255))});
                sent++;
            end else begin
                do cmd = 8'($urandom_range(0, 255));
                while (cmd == CMD_ERASE || cmd == CMD_PROGRAM || cmd == CMD_READ ||
                       cmd == CMD_RESET_A || cmd == CMD_RESET_B);
                send_word({cmd, 8'($urandom_range(0, 255))});
                sent++;
            end
        end
    endtask

    initial begin
        int          tick;
        int          style;
        tick        = 0;
        style       = 0;
        tx_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && tx_if.valid && tx_if.ready)
                sb.check_result(tx_if.action, tx_if.address, tx_if.data, tx_if.last);
            tick++;
            if (tick % 300 == 0) style = $urandom_range(0, 3);
            case (style)
                0: tx_if.ready <= 1'b1;
                1: tx_if.ready <= ($urandom_range(0, 1) == 1);
                2: tx_if.ready <= ($urandom_range(0, 5) == 0);
                default: tx_if.ready <= ((tick / 16) % 2 == 0);
            endcase
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("spi_flash_update_command_engine_core regression: fail");
        $finish;
    end

    initial begin
        int          variant;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [7:0]  lim;
        rx_if.valid   = 1'b0;
        rx_if.rx_word = 16'd0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_BASE_ADDRESS;
        i_cfg_wdata   = 32'd0;
        i_rst_n       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults straight out of reset
        send_word({CMD_ERASE, 8'd30});
        send_word({CMD_ERASE, 8'd1});
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word({CMD_RESET_A, 8'hA5});
        settle();

        // erase wraps past the top of the address space; a page limit above the cap
        load_config(32'hFFFF_F800, 8'd255, 16'd0, 16'hFFFF);
        send_word({CMD_ERASE, 8'd30});
        send_word({CMD_PROGRAM, 8'h00});
        send_word(16'd0);
        send_word({CMD_READ, 8'hFF});
        send_word(16'd0);
        send_word({CMD_PROGRAM, 8'h12});
        send_word(16'd3);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word({CMD_RESET_A, 8'h00});
        send_word({CMD_READ, 8'h00});
        send_word(16'd2);
        send_word(16'hFFFF);
        send_word({CMD_ERASE, 8'h00});
        send_word({CMD_RESET_B, 8'hFF});
        send_word(16'h63FF);
        send_word(16'h6700);
        send_word({CMD_ERASE, 8'd1});
        settle();

        load_config(RST_BASE_ADDRESS, RST_MAX_ERASE, RST_MIN_WORDS, RST_MAX_WORDS);
        run_traffic(60);
        settle();

        lo = 16'($urandom_range(0, 4));
        load_config(32'($urandom), 8'($urandom_range(1, 30)), lo,
                    lo + 16'($urandom_range(0, 20)));
        run_traffic(110);
        settle();

        load_config(32'd0, 8'd1, 16'd0, 16'd0);
        run_traffic(60);
        settle();

        // program and read addresses wrap at 32 bits
        load_config(32'hFFFF_FFFC, 8'($urandom_range(31, 254)), 16'd3, 16'd3);
        run_traffic(80);
        settle();

        // one way into the halted state, then words that must be ignored
        variant = $urandom_range(0, 4);
        lo = 16'($urandom_range(1, 100));
        hi = (variant == 4) ? lo - 16'd1 : lo + 16'($urandom_range(0, 100));
        load_config(32'($urandom), 8'($urandom_range(1, 255)), lo, hi);
        lim = (sb.max_erase < ERASE_CAP) ? sb.max_erase : ERASE_CAP;
        case (variant)
            0: send_word({CMD_ERASE, 8'd0});
            1: send_word({CMD_ERASE, 8'($urandom_range(int'(lim) + 1, 255))});
            default: begin
                send_word({(($urandom_range(0, 1) != 0) ? CMD_PROGRAM : CMD_READ),
                           8'($urandom_range(0, 255))});
                if (variant == 2) send_word(16'($urandom_range(0, int'(lo) - 1)));
                else if (variant == 3) send_word(16'($urandom_range(int'(hi) + 1, 65535)));
                else send_word(16'($urandom_range(0, 65535)));
            end
        endcase
        repeat (6) send_word(16'($urandom_range(0, 65535)));
        settle();

        if (sb.pending.size() != 0) sb.errors++;
        $display("Sent %0d words over %0d register settings; %0d output items compared.",
                 sb.words_noted, settings + 1, sb.checked);
        if (sb.errors == 0)
            $display("spi_flash_update_command_engine_core regression: pass");
        else
            $display("spi_flash_update_command_engine_core regression: fail");
        $finish;
    end

endmodule
